// File: hw/rtl/nrth_pkg.sv
// Shared types and constants for the nearest ray/triangle hit block.
// Payload structs, ray configuration struct, sequencer codes.
// No dependencies.
`default_nettype none

package nrth_pkg;

  localparam int COORD_BITS = 32;
  localparam int INDEX_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int QDIV_BITS  = COORD_BITS + FRAC_BITS;
  localparam int CFG_IDX_BITS = 3;
  localparam int QUEUE_DEPTH  = 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [INDEX_BITS-1:0] index_t;

  localparam coord_t QMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t QMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam coord_t ONE_Q = coord_t'(1) <<< FRAC_BITS;

  typedef struct packed {
    logic   func;
    coord_t v0_x;
    coord_t v0_y;
    coord_t v0_z;
    coord_t v1_x;
    coord_t v1_y;
    coord_t v1_z;
    coord_t v2_x;
    coord_t v2_y;
    coord_t v2_z;
    index_t tri_index;
    logic   last;
  } in_item_t;

  typedef struct packed {
    logic   hit;
    index_t hit_index;
    coord_t hit_t;
  } out_item_t;

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
    coord_t min_t;
    coord_t max_t;
  } ray_cfg_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_DIR_X    = 3'd3,
    CFG_DIR_Y    = 3'd4,
    CFG_DIR_Z    = 3'd5,
    CFG_MIN_T    = 3'd6,
    CFG_MAX_T    = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_ACC,
    ST_DSTART,
    ST_DWAIT,
    ST_CHECK,
    ST_FINISH
  } state_t;

  // Product sequences: two cross products, four dot products.
  typedef enum logic [2:0] {
    OP_S1,
    OP_DIV,
    OP_N1,
    OP_S2,
    OP_N2,
    OP_N3
  } op_t;

endpackage

`default_nettype wire

// File: hw/rtl/nearest_ray_triangle_hit.sv
// Top level of the nearest ray/triangle hit block: ray registers, front queue, back sequencer.
// Depends on nrth_pkg, nrth_front, nrth_back.
`default_nettype none

// Triangles stream in on in_valid/in_stall against the ray held in eight
// configuration registers (origin, direction, min_t, max_t; written by index
// while the block is idle, a rule on the user that the block itself does not
// enforce). Each triangle gets a Moller-Trumbore test in signed Q16.16 with
// saturating arithmetic. A two-entry queue takes triangles while the back end
// works. The back end runs every product through one shared 32x32 multiplier
// (24 products at most) and every quotient through a restoring divider at one
// bit per cycle (up to three quotients, each followed by a range check). A
// triangle is taken from the queue, its edges are formed, its products and
// quotients run and it finishes; it ends early when the divisor is zero or
// when the first or the second barycentric coordinate is out of range. The
// triangle marked last produces one result (hit, hit_index, hit_t) in an
// output register and holds in its finish state while that register is still
// stalled; a new group starts with the next triangle and picks up max_t then.
module nearest_ray_triangle_hit import nrth_pkg::*; (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  wire                      out_stall,
  output out_item_t                out_data,
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire  [CFG_IDX_BITS-1:0]  cfg_index,
  input  coord_t                   cfg_data
);

  ray_cfg_t ray_r;
  in_item_t q_item;
  logic     q_valid, q_pop;

  assign cfg_ready = 1'b1;

  // ray registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ray_r <= '{max_t: QMAX, default: '0};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ORIGIN_X: ray_r.origin_x <= cfg_data;
        CFG_ORIGIN_Y: ray_r.origin_y <= cfg_data;
        CFG_ORIGIN_Z: ray_r.origin_z <= cfg_data;
        CFG_DIR_X:    ray_r.dir_x    <= cfg_data;
        CFG_DIR_Y:    ray_r.dir_y    <= cfg_data;
        CFG_DIR_Z:    ray_r.dir_z    <= cfg_data;
        CFG_MIN_T:    ray_r.min_t    <= cfg_data;
        CFG_MAX_T:    ray_r.max_t    <= cfg_data;
        default:      ray_r          <= ray_r;
      endcase
    end
  end

  nrth_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  nrth_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ray       (ray_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: hw/rtl/nrth_front.sv
// Front end: accepts triangles and buffers them in a two-entry queue.
// Depends on nrth_pkg.
`default_nettype none

module nrth_front import nrth_pkg::*; (
  input  wire       clk,
  input  wire       rst_n,
  input  wire       in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      q_valid,
  output in_item_t  q_item,
  input  wire       q_pop
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  in_item_t           slot_r [QUEUE_DEPTH];
  logic [PW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [PW:0]        count_r;
  logic               push;

  assign in_stall = (count_r == (PW+1)'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_item   = slot_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/nrth_div.sv
// Restoring divider, one quotient bit per cycle, for the barycentric and t quotients.
// Computes (num << FRAC_BITS) / den on magnitudes. Depends on nrth_pkg.
`default_nettype none

module nrth_div import nrth_pkg::*; (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  input  wire  [COORD_BITS-1:0]       num_mag,
  input  wire  [COORD_BITS-1:0]       den_mag,
  output logic                        done,
  output logic [QDIV_BITS-1:0]        quot
);

  localparam int CW = $clog2(QDIV_BITS + 1);
  localparam logic [CW-1:0] CNT_LAST = CW'(QDIV_BITS - 1);

  logic [QDIV_BITS-1:0]  dvd_r, dvd_nxt;
  logic [COORD_BITS-1:0] rem_r, rem_nxt, den_r;
  logic [CW-1:0]         cnt_r;
  logic                  busy_r, done_r;
  logic [COORD_BITS:0]   rem_sh;
  logic                  ge;

  // one shift/subtract step
  always_comb begin
    rem_sh  = {rem_r, dvd_r[QDIV_BITS-1]};
    ge      = (rem_sh >= {1'b0, den_r});
    rem_nxt = ge ? COORD_BITS'(rem_sh - {1'b0, den_r}) : rem_sh[COORD_BITS-1:0];
    dvd_nxt = {dvd_r[QDIV_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= {num_mag, {FRAC_BITS{1'b0}}};
      rem_r <= '0;
      den_r <= den_mag;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = dvd_r;

endmodule

`default_nettype wire

// File: hw/rtl/nrth_back.sv
// Back end: sequences the Moller-Trumbore test over one shared multiplier
// and the divider, tracks the group's nearest hit and drives the result register.
// Depends on nrth_pkg and nrth_div.
`default_nettype none

module nrth_back import nrth_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  input  ray_cfg_t   ray,
  input  wire        q_valid,
  input  in_item_t   q_item,
  output logic       q_pop,
  output logic       out_valid,
  input  wire        out_stall,
  output out_item_t  out_data
);

  localparam int W  = COORD_BITS;
  localparam int PW = 2 * W;
  localparam logic [PW-1:0] MAG_POS_MAX = PW'(QMAX);
  localparam logic [PW-1:0] MAG_NEG_MAX = PW'(1) << (W - 1);
  localparam logic [PW-1:0] RND_HALF    = PW'(1) << (FRAC_BITS - 1);
  localparam coord_t BARY_LO = -coord_t'(1);
  localparam coord_t BARY_HI = ONE_Q + coord_t'(1);
  localparam logic signed [W:0] BARY_HI_X = {BARY_HI[W-1], BARY_HI};

  // saturating add or subtract of two Q16.16 values
  function automatic coord_t sat2(coord_t a, coord_t b, logic sub);
    logic signed [W:0] s;
    s = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
    if (s[W] != s[W-1]) begin
      return s[W] ? QMIN : QMAX;
    end
    return s[W-1:0];
  endfunction

  // signed value from a magnitude and a sign, saturated
  function automatic coord_t from_mag(logic [PW-1:0] m, logic neg);
    if (!neg) begin
      return (m > MAG_POS_MAX) ? QMAX : m[W-1:0];
    end
    if (m > MAG_NEG_MAX) begin
      return QMIN;
    end
    return -$signed(m[W-1:0]);
  endfunction

  function automatic logic [W-1:0] abs_mag(coord_t a);
    return a[W-1] ? (~a + 1'b1) : a;
  endfunction

  state_t  state_r, state_nxt;
  op_t     op_r;
  logic [2:0] p_r;
  in_item_t cur_r;

  coord_t e1_r [3];
  coord_t e2_r [3];
  coord_t d_r  [3];
  coord_t s1_r [3];
  coord_t s2_r [3];
  coord_t acc_r, div_r, num_r, b1_r, nearest_r;
  index_t best_r;
  logic   found_r, open_r, neg_r;
  logic signed [PW-1:0] prod_r;
  out_item_t out_r;
  logic      out_valid_r;

  // operand selection
  coord_t va [3];
  coord_t vb [3];
  logic [1:0] ia, ib;
  coord_t mul_a, mul_b;
  logic   is_cross, last_prod;

  always_comb begin
    case (op_r)
      OP_S1: begin
        va[0] = ray.dir_x; va[1] = ray.dir_y; va[2] = ray.dir_z;
        vb = e2_r;
      end
      OP_DIV: begin va = s1_r; vb = e1_r; end
      OP_N1:  begin va = d_r;  vb = s1_r; end
      OP_S2:  begin va = d_r;  vb = e1_r; end
      OP_N2: begin
        va[0] = ray.dir_x; va[1] = ray.dir_y; va[2] = ray.dir_z;
        vb = s2_r;
      end
      default: begin va = e2_r; vb = s2_r; end
    endcase
  end

  assign is_cross  = (op_r == OP_S1) || (op_r == OP_S2);
  assign last_prod = is_cross ? (p_r == 3'd5) : (p_r == 3'd2);

  // term order of a cross product: (a1 b2 - a2 b1, a2 b0 - a0 b2, a0 b1 - a1 b0)
  always_comb begin
    if (is_cross) begin
      case (p_r)
        3'd0:    begin ia = 2'd1; ib = 2'd2; end
        3'd1:    begin ia = 2'd2; ib = 2'd1; end
        3'd2:    begin ia = 2'd2; ib = 2'd0; end
        3'd3:    begin ia = 2'd0; ib = 2'd2; end
        3'd4:    begin ia = 2'd0; ib = 2'd1; end
        default: begin ia = 2'd1; ib = 2'd0; end
      endcase
    end else begin
      ia = p_r[1:0];
      ib = p_r[1:0];
    end
  end

  assign mul_a = va[ia];
  assign mul_b = vb[ib];

  // rounding and saturation of the registered product, then accumulate
  logic            pneg;
  logic [PW-1:0]   pmag, prnd;
  coord_t          m_q, acc_sum;

  always_comb begin
    pneg    = prod_r[PW-1];
    pmag    = pneg ? PW'(-prod_r) : PW'(prod_r);
    prnd    = (pmag + RND_HALF) >> FRAC_BITS;
    m_q     = from_mag(prnd, pneg);
    acc_sum = sat2(acc_r, m_q, is_cross);
  end

  // divider
  logic                 div_start, div_done;
  logic [QDIV_BITS-1:0] div_q;
  coord_t               qv;
  logic signed [W:0]    b12;
  logic                 b1_bad, b2_bad, t_ok;

  nrth_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num_mag (abs_mag(num_r)),
    .den_mag (abs_mag(div_r)),
    .done    (div_done),
    .quot    (div_q)
  );

  always_comb begin
    qv     = from_mag(PW'(div_q), neg_r);
    b12    = {b1_r[W-1], b1_r} + {qv[W-1], qv};
    b1_bad = (qv < BARY_LO) || (qv > BARY_HI);
    b2_bad = (qv < BARY_LO) || (b12 > BARY_HI_X);
    t_ok   = (qv >= ray.min_t) && (qv <= nearest_r);
  end

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (q_valid) state_nxt = ST_LOAD;
      ST_LOAD:   state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_ACC;
      ST_ACC: begin
        if (!last_prod) begin
          state_nxt = ST_MUL;
        end else begin
          case (op_r)
            OP_DIV:  state_nxt = (acc_sum == '0) ? ST_FINISH : ST_MUL;
            OP_N1, OP_N2, OP_N3: state_nxt = ST_DSTART;
            default: state_nxt = ST_MUL;
          endcase
        end
      end
      ST_DSTART: state_nxt = ST_DWAIT;
      ST_DWAIT:  if (div_done) state_nxt = ST_CHECK;
      ST_CHECK: begin
        case (op_r)
          OP_N1:   state_nxt = b1_bad ? ST_FINISH : ST_MUL;
          OP_N2:   state_nxt = b2_bad ? ST_FINISH : ST_MUL;
          default: state_nxt = ST_FINISH;
        endcase
      end
      ST_FINISH: if (!cur_r.last || out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // handshake outputs of the sequencer
  always_comb begin
    q_pop     = (state_r == ST_IDLE) && q_valid;
    div_start = (state_r == ST_DSTART);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        cur_r <= q_item;
      end
      ST_LOAD: begin
        e1_r[0] <= sat2(cur_r.v1_x, cur_r.v0_x, 1'b1);
        e1_r[1] <= sat2(cur_r.v1_y, cur_r.v0_y, 1'b1);
        e1_r[2] <= sat2(cur_r.v1_z, cur_r.v0_z, 1'b1);
        e2_r[0] <= sat2(cur_r.v2_x, cur_r.v0_x, 1'b1);
        e2_r[1] <= sat2(cur_r.v2_y, cur_r.v0_y, 1'b1);
        e2_r[2] <= sat2(cur_r.v2_z, cur_r.v0_z, 1'b1);
        d_r[0]  <= sat2(ray.origin_x, cur_r.v0_x, 1'b1);
        d_r[1]  <= sat2(ray.origin_y, cur_r.v0_y, 1'b1);
        d_r[2]  <= sat2(ray.origin_z, cur_r.v0_z, 1'b1);
        op_r    <= OP_S1;
        p_r     <= '0;
      end
      ST_MUL: begin
        prod_r <= mul_a * mul_b;
      end
      ST_ACC: begin
        p_r <= last_prod ? 3'd0 : p_r + 3'd1;
        if (is_cross) begin
          if (!p_r[0]) begin
            acc_r <= m_q;
          end else if (op_r == OP_S1) begin
            s1_r[p_r[2:1]] <= acc_sum;
          end else begin
            s2_r[p_r[2:1]] <= acc_sum;
          end
        end else if (p_r == 3'd0) begin
          acc_r <= m_q;
        end else if (p_r == 3'd1) begin
          acc_r <= acc_sum;
        end else if (op_r == OP_DIV) begin
          div_r <= acc_sum;
        end else begin
          num_r <= acc_sum;
        end
        if (last_prod) begin
          case (op_r)
            OP_S1:   op_r <= OP_DIV;
            OP_DIV:  op_r <= OP_N1;
            OP_S2:   op_r <= OP_N2;
            default: op_r <= op_r;
          endcase
        end
      end
      ST_DSTART: begin
        neg_r <= num_r[W-1] ^ div_r[W-1];
      end
      ST_CHECK: begin
        case (op_r)
          OP_N1: begin
            b1_r <= qv;
            op_r <= OP_S2;
          end
          OP_N2:   op_r <= OP_N3;
          default: op_r <= op_r;
        endcase
      end
      default: begin
      end
    endcase
  end

  // group state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r      <= 1'b0;
      found_r     <= 1'b0;
      best_r      <= '0;
      nearest_r   <= QMAX;
      out_valid_r <= 1'b0;
    end else begin
      // drop the result after its transfer unless a new one replaces it
      if (out_valid_r && !out_stall && !(state_r == ST_FINISH && cur_r.last)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          // first triangle of a group reloads the search state
          if (q_valid && !open_r) begin
            open_r    <= 1'b1;
            found_r   <= 1'b0;
            best_r    <= '0;
            nearest_r <= ray.max_t;
          end
        end
        ST_CHECK: begin
          if (op_r == OP_N3 && t_ok) begin
            found_r <= 1'b1;
            if (!cur_r.func) begin
              nearest_r <= qv;
              best_r    <= cur_r.tri_index;
            end
          end
        end
        ST_FINISH: begin
          if (cur_r.last && out_free) begin
            out_r.hit       <= found_r;
            out_r.hit_index <= found_r ? best_r : '0;
            out_r.hit_t     <= found_r ? nearest_r : QMAX;
            out_valid_r     <= 1'b1;
            open_r          <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// File: tb/sv/tb_nearest_ray_triangle_hit.sv
// Testbench for nearest_ray_triangle_hit: directed, random and backpressure tests
// checked against an in-bench Moller-Trumbore predictor in saturating Q16.16.
// Depends on nrth_pkg and the nearest_ray_triangle_hit RTL.
`timescale 1ns / 100ps

module tb_nearest_ray_triangle_hit;
  import nrth_pkg::*;

  localparam int DRAIN_CYCLES = 700;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
  } vec3_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  coord_t cfg_data = '0;

  // ray registers as seen by the predictor, plus group state
  longint ray_org[3];
  longint ray_dir[3];
  longint ray_min_t;
  longint ray_max_t;
  longint near_t;
  index_t near_index;
  logic any_found;
  logic group_open;

  out_item_t hits_pending[$];
  int mismatches = 0;
  int failures = 0;
  bit quiet = 0;
  int hold_cycles = 0;

  nearest_ray_triangle_hit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------- saturating Q16.16 arithmetic ----------------
  function automatic longint sat_q(longint v);
    return (v > Q_MAX) ? Q_MAX : ((v < Q_MIN) ? Q_MIN : v);
  endfunction

  function automatic longint from_mag(longint unsigned m, bit neg);
    if (!neg) return (m > 64'd2147483647) ? Q_MAX : longint'(m);
    if (m > 64'd2147483648) return Q_MIN;
    return -longint'(m);
  endfunction

  function automatic longint unsigned mag_of(longint a);
    return (a < 0) ? longint'(-a) : a;
  endfunction

  function automatic longint q_mul(longint a, longint b);
    longint unsigned p;
    p = mag_of(a) * mag_of(b) + 64'd32768;
    return from_mag(p >> 16, (a < 0) != (b < 0));
  endfunction

  function automatic longint q_div(longint n, longint d);
    return from_mag((mag_of(n) << 16) / mag_of(d), (n < 0) != (d < 0));
  endfunction

  function automatic vec3_t v_sub(vec3_t a, vec3_t b);
    vec3_t r;
    r.x = sat_q(a.x - b.x);
    r.y = sat_q(a.y - b.y);
    r.z = sat_q(a.z - b.z);
    return r;
  endfunction

  function automatic vec3_t v_cross(vec3_t a, vec3_t b);
    vec3_t r;
    r.x = sat_q(q_mul(a.y, b.z) - q_mul(a.z, b.y));
    r.y = sat_q(q_mul(a.z, b.x) - q_mul(a.x, b.z));
    r.z = sat_q(q_mul(a.x, b.y) - q_mul(a.y, b.x));
    return r;
  endfunction

  function automatic longint v_dot(vec3_t a, vec3_t b);
    longint s;
    s = sat_q(q_mul(a.x, b.x) + q_mul(a.y, b.y));
    return sat_q(s + q_mul(a.z, b.z));
  endfunction

  // Moller-Trumbore on one accepted triangle; queues the group result on last
  task automatic track_triangle(in_item_t it);
    vec3_t v0, v1, v2, org, dir, e1, e2, s1, s2, dv;
    longint dvsr, b1, b2, t;
    bit ok;
    out_item_t res;
    v0 = '{longint'(it.v0_x), longint'(it.v0_y), longint'(it.v0_z)};
    v1 = '{longint'(it.v1_x), longint'(it.v1_y), longint'(it.v1_z)};
    v2 = '{longint'(it.v2_x), longint'(it.v2_y), longint'(it.v2_z)};
    org = '{ray_org[0], ray_org[1], ray_org[2]};
    dir = '{ray_dir[0], ray_dir[1], ray_dir[2]};
    if (!group_open) begin
      near_t = ray_max_t;
      near_index = '0;
      any_found = 1'b0;
      group_open = 1'b1;
    end
    ok = 1;
    t = 0;
    b1 = 0;
    e1 = v_sub(v1, v0);
    e2 = v_sub(v2, v0);
    s1 = v_cross(dir, e2);
    dvsr = v_dot(s1, e1);
    if (dvsr == 0) ok = 0;
    if (ok) begin
      dv = v_sub(org, v0);
      b1 = q_div(v_dot(dv, s1), dvsr);
      if (b1 < -1 || b1 > 65537) ok = 0;
    end
    if (ok) begin
      s2 = v_cross(dv, e1);
      b2 = q_div(v_dot(dir, s2), dvsr);
      if (b2 < -1 || b1 + b2 > 65537) ok = 0;
      else t = q_div(v_dot(e2, s2), dvsr);
    end
    if (ok && t >= ray_min_t && t <= near_t) begin
      any_found = 1'b1;
      if (!it.func) begin
        near_t = t;
        near_index = it.tri_index;
      end
    end
    if (it.last) begin
      res.hit = any_found;
      res.hit_index = any_found ? near_index : '0;
      res.hit_t = any_found ? coord_t'(near_t) : QMAX;
      hits_pending.push_back(res);
      group_open = 1'b0;
    end
  endtask

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (hits_pending.size() == 0) begin
        failures++;
        if (mismatches++ < 10) $display("unexpected result %p", out_data);
      end else begin
        want = hits_pending.pop_front();
        if (out_data.hit !== want.hit || out_data.hit_index !== want.hit_index ||
            out_data.hit_t !== want.hit_t) begin
          failures++;
          if (mismatches++ < 10)
            $display("result mismatch: expected hit=%0b idx=%0d t=%0d, got hit=%0b idx=%0d t=%0d",
                     want.hit, want.hit_index, want.hit_t,
                     out_data.hit, out_data.hit_index, out_data.hit_t);
        end
      end
    end
  end

  // ---------------- result side stalls ----------------
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall = 1'b1;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      n = quiet ? 0 : $urandom_range(0, 10);
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid && hold_cycles == 0);
    end
  end

  // ---------------- stimulus helpers ----------------
  task automatic send_triangle(in_item_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (in_stall);
    track_triangle(it);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, coord_t val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ORIGIN_X, CFG_ORIGIN_Y, CFG_ORIGIN_Z: ray_org[idx - CFG_ORIGIN_X] = val;
      CFG_DIR_X, CFG_DIR_Y, CFG_DIR_Z: ray_dir[idx - CFG_DIR_X] = val;
      CFG_MIN_T: ray_min_t = val;
      default: ray_max_t = val;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_ray(coord_t ox, coord_t oy, coord_t oz, coord_t dx, coord_t dy,
                         coord_t dz, coord_t tmin, coord_t tmax);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_ORIGIN_Z, oz);
    write_reg(CFG_DIR_X, dx);
    write_reg(CFG_DIR_Y, dy);
    write_reg(CFG_DIR_Z, dz);
    write_reg(CFG_MIN_T, tmin);
    write_reg(CFG_MAX_T, tmax);
  endtask

  // wait until every result is in, then let any trailing triangle finish
  task automatic settle();
    in_valid = 1'b0;
    while (hits_pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic in_item_t make_tri(bit any, coord_t ax, coord_t ay, coord_t az,
                                        coord_t bx, coord_t by, coord_t bz, coord_t cx,
                                        coord_t cy, coord_t cz, index_t idx, bit lst);
    in_item_t it;
    it = '{any, ax, ay, az, bx, by, bz, cx, cy, cz, idx, lst};
    return it;
  endfunction

  function automatic coord_t small_q(int range_q);
    return coord_t'($signed($urandom_range(0, 2 * range_q)) - range_q);
  endfunction

  // triangle placed around the point the ray reaches at a random t
  function automatic in_item_t near_tri(index_t idx, bit lst);
    in_item_t it;
    longint t0, c[3];
    t0 = $urandom_range(0, 20 * 65536);
    for (int k = 0; k < 3; k++) c[k] = sat_q(ray_org[k] + q_mul(ray_dir[k], t0));
    it.func = $urandom_range(0, 3) == 0;
    it.v0_x = coord_t'(sat_q(c[0] + small_q(4 << 16)));
    it.v0_y = coord_t'(sat_q(c[1] + small_q(4 << 16)));
    it.v0_z = coord_t'(sat_q(c[2] + small_q(4 << 16)));
    it.v1_x = coord_t'(sat_q(c[0] + small_q(4 << 16)));
    it.v1_y = coord_t'(sat_q(c[1] + small_q(4 << 16)));
    it.v1_z = coord_t'(sat_q(c[2] + small_q(4 << 16)));
    it.v2_x = coord_t'(sat_q(c[0] + small_q(4 << 16)));
    it.v2_y = coord_t'(sat_q(c[1] + small_q(4 << 16)));
    it.v2_z = coord_t'(sat_q(c[2] + small_q(4 << 16)));
    it.tri_index = idx;
    it.last = lst;
    return it;
  endfunction

  function automatic in_item_t noise_tri(bit lst);
    in_item_t it;
    it = '{1'($urandom), coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
           coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
           coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
           index_t'($urandom), lst};
    return it;
  endfunction

  // random groups; mostly triangles near the ray, some raw noise
  task automatic run_groups(int count);
    int sent, len;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 4) == 0) send_triangle(noise_tri(k == len - 1));
        else send_triangle(near_tri(index_t'($urandom), k == len - 1));
      end
      sent += len;
    end
  endtask

  // ---------------- tests ----------------
  task automatic test_directed();
    coord_t one, two, m1;
    one = ONE_Q;
    two = ONE_Q <<< 1;
    m1 = -ONE_Q;
    // ray from z=-5 toward +z, unit triangles in planes z=0 and z=2
    set_ray('0, '0, -5 * ONE_Q, '0, '0, one, '0, QMAX);
    // closest hit, then a nearer one, then a tie that replaces it
    send_triangle(make_tri(1'b0, m1, m1, two, one, m1, two, '0, one, two, 16'd5, 1'b0));
    send_triangle(make_tri(1'b0, m1, m1, '0, one, m1, '0, '0, one, '0, 16'd9, 1'b0));
    send_triangle(make_tri(1'b0, m1, m1, '0, one, m1, '0, '0, one, '0, 16'hffff, 1'b1));
    // any-hit only group: fields stay at their no-hit values
    send_triangle(make_tri(1'b1, m1, m1, '0, one, m1, '0, '0, one, '0, 16'd3, 1'b1));
    // mixed modes: any-hit nearer does not move the closest hit
    send_triangle(make_tri(1'b0, m1, m1, two, one, m1, two, '0, one, two, 16'd7, 1'b0));
    send_triangle(make_tri(1'b1, m1, m1, '0, one, m1, '0, '0, one, '0, 16'd8, 1'b1));
    // degenerate triangle, miss to the side, then vertex extremes
    send_triangle(make_tri(1'b0, one, one, one, one, one, one, one, one, one, 16'd1, 1'b0));
    send_triangle(make_tri(1'b0, 5 * ONE_Q, 5 * ONE_Q, '0, 7 * ONE_Q, 5 * ONE_Q, '0,
                           6 * ONE_Q, 7 * ONE_Q, '0, 16'd2, 1'b1));
    send_triangle(make_tri(1'b0, QMIN, QMIN, QMIN, QMAX, QMIN, '0, '0, QMAX, QMAX, '0,
                           1'b0));
    send_triangle(make_tri(1'b0, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMIN, QMIN, QMIN,
                           16'hffff, 1'b1));
    send_triangle(make_tri(1'b1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, 1'b1));
    settle();
    // interval limits: min_t beyond the plane z=0, then a max_t at that plane and below z=2
    set_ray('0, '0, -5 * ONE_Q, '0, '0, one, 6 * ONE_Q, QMAX);
    send_triangle(make_tri(1'b0, m1, m1, '0, one, m1, '0, '0, one, '0, 16'd4, 1'b1));
    settle();
    set_ray('0, '0, -5 * ONE_Q, '0, '0, one, '0, 5 * ONE_Q);
    send_triangle(make_tri(1'b0, m1, m1, '0, one, m1, '0, '0, one, '0, 16'd4, 1'b0));
    send_triangle(make_tri(1'b0, m1, m1, two, one, m1, two, '0, one, two, 16'd6, 1'b1));
    settle();
    // zero direction: every divisor is zero
    set_ray('0, '0, '0, '0, '0, '0, QMIN, QMAX);
    send_triangle(make_tri(1'b0, m1, m1, '0, one, m1, '0, '0, one, '0, 16'd4, 1'b1));
    settle();
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 6; ph++) begin
      quiet = (ph == 2);
      case (ph)
        0: set_ray(small_q(16 << 16), small_q(16 << 16), small_q(16 << 16),
                   small_q(2 << 16), small_q(2 << 16), small_q(2 << 16), '0, QMAX);
        1: set_ray(small_q(16 << 16), small_q(16 << 16), small_q(16 << 16),
                   small_q(2 << 16), small_q(2 << 16), small_q(2 << 16), QMIN, QMAX);
        2: set_ray(small_q(16 << 16), small_q(16 << 16), small_q(16 << 16),
                   small_q(2 << 16), small_q(2 << 16), small_q(2 << 16),
                   ONE_Q, 10 * ONE_Q);
        3: set_ray(QMAX, QMIN, small_q(8 << 16), QMIN, QMAX, small_q(2 << 16), QMIN, QMIN);
        4: set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom);
        default: set_ray(small_q(16 << 16), small_q(16 << 16), small_q(16 << 16),
                         small_q(2 << 16), small_q(2 << 16), small_q(2 << 16),
                         small_q(4 << 16), QMAX);
      endcase
      run_groups(210);
      settle();
    end
    quiet = 0;
  endtask

  // receiver holds off while triangles keep coming, so the queue fills up
  task automatic test_backpressure();
    set_ray('0, '0, -8 * ONE_Q, small_q(1 << 15), small_q(1 << 15), ONE_Q, '0, QMAX);
    hold_cycles = 3000;
    quiet = 1;
    for (int k = 0; k < 24; k++) send_triangle(near_tri(index_t'(k), (k % 2) == 1));
    quiet = 0;
    settle();
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_random();
    test_backpressure();
    if (failures == 0 && hits_pending.size() == 0) begin
      $display("tb_nearest_ray_triangle_hit: clean");
    end else begin
      $display("tb_nearest_ray_triangle_hit: errors");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("tb_nearest_ray_triangle_hit: errors");
    $finish;
  end

endmodule
